// File: rtl/core/binary_min_heap_queue_assert.svh
// Assertion macros shared by the checker files of the binary min-heap queue.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define BMHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define BMHQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/core/bmhq_pkg.sv
// Package of the binary min-heap queue: sizes, codes, entry and control types.
// Depends on nothing; all files of the block import it but the RAM and the macros.
`default_nettype none

package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IDX_W      = ADDR_W + 2;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 11;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                     kind;
    logic signed [KEY_W-1:0]  key;
    logic signed [PRIO_W-1:0] prio;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  key;
    logic signed [PRIO_W-1:0] prio;
    logic [FILL_W-1:0]        fill;
  } result_t;

  // Access request from the sift engine to the entry memory.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_EXT_ROOT,
    ST_EXT_LAST,
    ST_DN_CHK,
    ST_DN_LEFT,
    ST_DN_RIGHT
  } eng_state_e;

endpackage

`default_nettype wire

// File: rtl/core/bmhq_req_if.sv
// Request channel of the binary min-heap queue: valid/ready plus one operation.
// Depends on bmhq_pkg for the field widths.
`default_nettype none

interface bmhq_req_if;
  import bmhq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [KEY_W-1:0]  entry_key;
  logic signed [PRIO_W-1:0] entry_priority;

  modport source (output valid, output kind, output entry_key, output entry_priority,
                  input ready);
  modport sink   (input valid, input kind, input entry_key, input entry_priority,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmhq_rsp_if.sv
// Response channel of the binary min-heap queue: valid/ready plus one result.
// Depends on bmhq_pkg for the field widths.
`default_nettype none

interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [KEY_W-1:0]  min_key;
  logic signed [PRIO_W-1:0] min_priority;
  logic [FILL_W-1:0]        fill_count;

  modport source (output valid, output status, output min_key, output min_priority,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input min_key, input min_priority,
                  input fill_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmhq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module bmhq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bmhq_sift.sv
// Sift engine of the binary min-heap queue: entry count, sift-up and sift-down.
// Depends on bmhq_pkg; drives the entry memory through a mem_req_t.
`default_nettype none

module bmhq_sift (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire bmhq_pkg::item_t      item_i,
  output      bmhq_pkg::mem_req_t   mem_o,
  input  wire bmhq_pkg::entry_t     rdata_i,
  output      bmhq_pkg::eng_status_t stat_o,
  output      bmhq_pkg::result_t    result_o
);
  import bmhq_pkg::*;

  eng_state_e              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [ADDR_W-1:0]       pos_q, pos_d;
  entry_t                  mov_q, mov_d;
  entry_t                  best_q, best_d;
  logic                    best_child_q, best_child_d;
  logic signed [KEY_W-1:0]  res_key_q, res_key_d;
  logic signed [PRIO_W-1:0] res_prio_q, res_prio_d;

  logic [IDX_W-1:0]  lc_idx, rc_idx, count_ext;
  logic [ADDR_W-1:0] parent_addr;
  logic              done;
  logic [STATUS_W-1:0] status;

  // The moving entry stays in mov_q; each level writes the displaced entry
  // into the hole and only the final level writes the moving entry.
  assign lc_idx      = IDX_W'({pos_q, 1'b1});
  assign rc_idx      = lc_idx + IDX_W'(1);
  assign count_ext   = IDX_W'(count_q);
  assign parent_addr = (pos_q - ADDR_W'(1)) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    mov_q        <= mov_d;
    best_q       <= best_d;
    best_child_q <= best_child_d;
    res_key_q    <= res_key_d;
    res_prio_q   <= res_prio_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    mov_d        = mov_q;
    best_d       = best_q;
    best_child_d = best_child_q;
    res_key_d    = res_key_q;
    res_prio_d   = res_prio_q;
    mem_o        = '0;
    mem_o.wdata  = mov_q;
    mem_o.waddr  = pos_q;
    done         = 1'b0;
    status       = STATUS_DONE;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_key_d  = '0;
          res_prio_d = '0;
          if (item_i.kind == KIND_INSERT) begin
            if (count_q == CNT_W'(HEAP_DEPTH)) begin
              done   = 1'b1;
              status = STATUS_FULL;
            end else begin
              mov_d   = '{key: item_i.key, prio: item_i.prio};
              pos_d   = count_q[ADDR_W-1:0];
              state_d = ST_INS_CHK;
            end
          end else begin
            if (count_q == '0) begin
              done   = 1'b1;
              status = STATUS_EMPTY;
            end else begin
              mem_o.re    = 1'b1;
              mem_o.raddr = '0;
              state_d     = ST_EXT_ROOT;
            end
          end
        end
      end

      ST_INS_CHK: begin
        if (pos_q == '0) begin
          mem_o.we = 1'b1;
          count_d  = count_q + CNT_W'(1);
          done     = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = parent_addr;
          state_d     = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_o.we = 1'b1;
        if (mov_q.prio < rdata_i.prio) begin
          mem_o.wdata = rdata_i;
          pos_d       = parent_addr;
          state_d     = ST_INS_CHK;
        end else begin
          count_d = count_q + CNT_W'(1);
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_EXT_ROOT: begin
        res_key_d   = rdata_i.key;
        res_prio_d  = rdata_i.prio;
        mem_o.re    = 1'b1;
        mem_o.raddr = ADDR_W'(count_q - CNT_W'(1));
        count_d     = count_q - CNT_W'(1);
        state_d     = ST_EXT_LAST;
      end

      ST_EXT_LAST: begin
        mov_d   = rdata_i;
        pos_d   = '0;
        state_d = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (lc_idx >= count_ext) begin
          mem_o.we = 1'b1;
          done     = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = lc_idx[ADDR_W-1:0];
          state_d     = ST_DN_LEFT;
        end
      end

      ST_DN_LEFT: begin
        best_child_d = (rdata_i.prio < mov_q.prio);
        best_d       = best_child_d ? rdata_i : mov_q;
        if (rc_idx < count_ext) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = rc_idx[ADDR_W-1:0];
          state_d     = ST_DN_RIGHT;
        end else if (best_child_d) begin
          // Only a left child, and it is smaller: it moves up into the hole.
          mem_o.we    = 1'b1;
          mem_o.wdata = rdata_i;
          pos_d       = lc_idx[ADDR_W-1:0];
          state_d     = ST_DN_CHK;
        end else begin
          mem_o.we = 1'b1;
          done     = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_DN_RIGHT: begin
        mem_o.we = 1'b1;
        if (rdata_i.prio < best_q.prio) begin
          mem_o.wdata = rdata_i;
          pos_d       = rc_idx[ADDR_W-1:0];
          state_d     = ST_DN_CHK;
        end else if (best_child_q) begin
          mem_o.wdata = best_q;
          pos_d       = lc_idx[ADDR_W-1:0];
          state_d     = ST_DN_CHK;
        end else begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = done;

  always_comb begin
    result_o.status = status;
    result_o.key    = (status == STATUS_DONE) ? res_key_q : '0;
    result_o.prio   = (status == STATUS_DONE) ? res_prio_q : '0;
    result_o.fill   = FILL_W'(count_d);
  end

endmodule

`default_nettype wire

// File: rtl/core/binary_min_heap_queue.sv
// Binary min-heap queue. An insert climbs one level at a time, reading the parent and
// writing one slot per level; an extract reads the root and the last entry, then descends
// a level at a time, reading the children and writing one slot; a refused operation
// touches no memory. One operation is in flight at a time; the next request transfer can
// come in the cycle after the response transfer. Reset clears the entry count and control
// state only; no clearing pass is needed, as slots past the count are never read.
`default_nettype none

module binary_min_heap_queue (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);
  import bmhq_pkg::*;

  // The heap array lives in one RAM of HEAP_DEPTH entries, each a key and a
  // priority. Slot 0 is the root; the children of slot i are 2i+1 and 2i+2.
  mem_req_t    mem_req;
  entry_t      mem_rdata;
  logic [ENTRY_W-1:0] mem_rdata_raw;

  item_t       item;
  eng_status_t eng_stat;
  result_t     eng_result;
  logic        start;

  // Response register: holds a finished result until its transfer completes.
  logic    rsp_valid_q, rsp_valid_d;
  result_t rsp_q;

  // A request is taken only when the engine is idle and the response register
  // is empty, so a single operation owns the memory from start to finish.
  assign req_i.ready = eng_stat.idle && !rsp_valid_q;
  assign start       = req_i.valid && req_i.ready;

  assign item.kind = req_i.kind;
  assign item.key  = req_i.entry_key;
  assign item.prio = req_i.entry_priority;

  bmhq_sift u_sift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (item),
    .mem_o    (mem_req),
    .rdata_i  (mem_rdata),
    .stat_o   (eng_stat),
    .result_o (eng_result)
  );

  bmhq_ram #(
    .Width (ENTRY_W),
    .Depth (HEAP_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata_raw)
  );

  assign mem_rdata = entry_t'(mem_rdata_raw);

  // The engine signals done for exactly one cycle per operation, and only
  // while the response register is empty.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (eng_stat.done) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_stat.done) begin
      rsp_q <= eng_result;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.min_key      = rsp_q.key;
  assign rsp_o.min_priority = rsp_q.prio;
  assign rsp_o.fill_count   = rsp_q.fill;

endmodule

`default_nettype wire

// File: rtl/core/bmhq_checker.sv
// Port-level checker of the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and the macros in binary_min_heap_queue_assert.svh.
`default_nettype none

`include "binary_min_heap_queue_assert.svh"

module bmhq_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [bmhq_pkg::STATUS_W-1:0] rsp_status_i,
  input wire logic [bmhq_pkg::KEY_W-1:0]    rsp_min_key_i,
  input wire logic [bmhq_pkg::PRIO_W-1:0]   rsp_min_priority_i,
  input wire logic [bmhq_pkg::FILL_W-1:0]   rsp_fill_count_i
);
  import bmhq_pkg::*;

  // A stalled response keeps its valid and its whole payload.
  `BMHQ_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_min_key_i) && $stable(rsp_min_priority_i) && $stable(rsp_fill_count_i))

  // Only one operation is in flight: ready drops right after a request transfer.
  `BMHQ_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // An error result carries no entry.
  `BMHQ_ASSERT_IMP(a_err_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != STATUS_DONE), (rsp_min_key_i == '0) && (rsp_min_priority_i == '0))

  // No new result can follow a response transfer in the very next cycle.
  `BMHQ_ASSERT_NXT(a_rsp_gap, clk_i, rst_ni, rsp_valid_i && rsp_ready_i, !rsp_valid_i)

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_min_key_i      (rsp_o.min_key),
  .rsp_min_priority_i (rsp_o.min_priority),
  .rsp_fill_count_i   (rsp_o.fill_count)
);

`default_nettype wire

// File: test/bmhq_heap_monitor.sv
`timescale 1ns / 1ps
// Heap monitor: watches the request and response channels of the heap queue,
// keeps its own copy of the heap to predict each response and compares the two.
// Depends on bmhq_pkg and the bmhq_req_if / bmhq_rsp_if channel interfaces.

module bmhq_heap_monitor
  import bmhq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bmhq_req_if       req_i,
  bmhq_rsp_if       rsp_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        inserts_o,
  output int        extracts_o,
  output int        empty_hits_o,
  output int        full_hits_o,
  output int        peak_fill_o
);

  localparam int MAX_REPORTS = 40;

  logic signed [KEY_W-1:0]  heap_key  [HEAP_DEPTH];
  logic signed [PRIO_W-1:0] heap_prio [HEAP_DEPTH];
  int unsigned              heap_fill;
  result_t                  predicted_q [$];

  int fails      = 0;
  int pending    = 0;
  int inserts    = 0;
  int extracts   = 0;
  int empty_hits = 0;
  int full_hits  = 0;
  int peak_fill  = 0;
  int rsp_seen   = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign inserts_o    = inserts;
  assign extracts_o   = extracts;
  assign empty_hits_o = empty_hits;
  assign full_hits_o  = full_hits;
  assign peak_fill_o  = peak_fill;

  task automatic report_mismatch(input string msg);
    if (fails < MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("response %0d %s: got 0x%08h, expected 0x%08h",
                                rsp_seen, name, got, want));
    end
  endtask

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic signed [KEY_W-1:0]  k;
    logic signed [PRIO_W-1:0] p;
    k = heap_key[a];
    p = heap_prio[a];
    heap_key[a]  = heap_key[b];
    heap_prio[a] = heap_prio[b];
    heap_key[b]  = k;
    heap_prio[b] = p;
  endfunction

  // Applies one operation to the shadow heap and returns the response it must
  // produce. Ties never swap, so equal priorities keep their slots.
  function automatic result_t heap_apply(input item_t op);
    result_t     res;
    int unsigned pos;
    int unsigned up;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    res = '0;
    res.status = STATUS_DONE;
    if (op.kind == KIND_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        pos = heap_fill;
        heap_key[pos]  = op.key;
        heap_prio[pos] = op.prio;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_prio[pos] >= heap_prio[up]) break;
          swap_slots(pos, up);
          pos = up;
        end
        heap_fill++;
      end
    end else if (heap_fill == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.key  = heap_key[0];
      res.prio = heap_prio[0];
      heap_fill--;
      heap_key[0]  = heap_key[heap_fill];
      heap_prio[0] = heap_prio[heap_fill];
      pos = 0;
      while (1) begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < heap_fill && heap_prio[lc] < heap_prio[best]) best = lc;
        if (rc < heap_fill && heap_prio[rc] < heap_prio[best]) best = rc;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
    res.fill = FILL_W'(heap_fill);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    item_t   op;
    if (!rst_ni) begin
      heap_fill = 0;
      predicted_q.delete();
      pending = 0;
    end else begin
      // A response can only belong to a request taken at an earlier edge.
      if (rsp_i.valid && rsp_i.ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                    rsp_seen));
        end else begin
          want = predicted_q.pop_front();
          check_field("status", 32'(rsp_i.status), 32'(want.status));
          check_field("min_key", rsp_i.min_key, want.key);
          check_field("min_priority", rsp_i.min_priority, want.prio);
          check_field("fill_count", 32'(rsp_i.fill_count), 32'(want.fill));
        end
        rsp_seen++;
      end
      if (req_i.valid && req_i.ready) begin
        op.kind = req_i.kind;
        op.key  = req_i.entry_key;
        op.prio = req_i.entry_priority;
        want = heap_apply(op);
        if (op.kind == KIND_INSERT) inserts++;
        else extracts++;
        if (want.status == STATUS_EMPTY) empty_hits++;
        if (want.status == STATUS_FULL) full_hits++;
        if (int'(heap_fill) > peak_fill) peak_fill = heap_fill;
        predicted_q.push_back(want);
      end
      pending = predicted_q.size();
    end
  end

endmodule

// File: test/tb_binary_min_heap_queue.sv
`timescale 1ns / 1ps
// Top of the heap queue testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on bmhq_pkg, the channel interfaces,
// the binary_min_heap_queue block and the bmhq_heap_monitor checker.

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  // Chance, in percent, that a side idles in a given cycle.
  localparam int unsigned IDLE_PCT      = 28;
  // The receiver goes quiet once, this many cycles after reset, for HOLD_CYCLES.
  localparam int unsigned HOLD_START    = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  // Cycles to linger after the last response.
  localparam int unsigned SETTLE_CYCLES = 60;
  // Worst case is about 1600 operations plus idling and the long hold; the
  // limit allows about eight times the time that takes.
  localparam longint      TIMEOUT_NS    = 5_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // While set, neither side idles, which gives a long stretch at full rate.
  bit steady = 1'b0;
  // Entries the heap holds, tracked only to steer the stimulus.
  int occupancy = 0;

  int fail_count;
  int pending;
  int inserts;
  int extracts;
  int empty_hits;
  int full_hits;
  int peak_fill;

  bmhq_req_if req ();
  bmhq_rsp_if rsp ();

  binary_min_heap_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  bmhq_heap_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .inserts_o    (inserts),
    .extracts_o   (extracts),
    .empty_hits_o (empty_hits),
    .full_hits_o  (full_hits),
    .peak_fill_o  (peak_fill)
  );

  always #5 clk_i = ~clk_i;

  // Priorities are drawn so that ties and the signed extremes come up often;
  // a narrow range around zero forces many equal-priority comparisons.
  function automatic logic signed [PRIO_W-1:0] rand_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return int'($urandom_range(0, 15)) - 8;
      8:             return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:       return int'($urandom_range(0, 3)) - 2;
    endcase
  endfunction

  // Offers one operation, starting at a falling edge, and returns at the falling
  // edge after its transfer. Random idle cycles come first unless steady is set.
  // Valid is assigned once per step, so back-to-back transfers keep it high.
  task automatic send_op(input logic kind, input logic signed [KEY_W-1:0] key,
                         input logic signed [PRIO_W-1:0] prio);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid          <= 1'b1;
    req.kind           <= kind;
    req.entry_key      <= key;
    req.entry_priority <= prio;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (kind == KIND_INSERT) begin
      if (occupancy < int'(HEAP_DEPTH)) occupancy++;
    end else if (occupancy > 0) begin
      occupancy--;
    end
  endtask

  // Receiver: accepts responses at random, except for one long hold counted in
  // cycles here. During the hold the sender keeps offering, so the block,
  // holding one result it cannot hand over, has to stall its request side.
  initial begin : receiver
    int unsigned cycle;
    bit          held;
    cycle = 0;
    held  = 1'b0;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle++;
      if (!held && cycle == HOLD_START) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    int n;
    req.valid          = 1'b0;
    req.kind           = KIND_INSERT;
    req.entry_key      = '0;
    req.entry_priority = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. An extract from the empty heap comes first, with junk in
    // the ignored fields, then the signed extremes, alternating bit patterns and
    // equal priorities, which the heap need not return in the order of insertion.
    send_op(KIND_EXTRACT, 32'sd123, -32'sd5);
    send_op(KIND_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_op(KIND_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_op(KIND_INSERT, 32'sd0, 32'sd0);
    send_op(KIND_INSERT, -32'sd1, -32'sd1);
    send_op(KIND_INSERT, 32'sd1, 32'sd0);
    send_op(KIND_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
    send_op(KIND_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
    send_op(KIND_INSERT, 32'sd2, 32'sd0);
    for (n = 0; n < 8; n++) send_op(KIND_EXTRACT, $urandom, $urandom);
    send_op(KIND_EXTRACT, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
    for (n = 0; n < 3; n++) send_op(KIND_INSERT, 32'sd10 + n, 32'sd7);
    for (n = 0; n < 3; n++) send_op(KIND_EXTRACT, $urandom, $urandom);

    // Mixed traffic around a shallow heap, so empty extracts keep coming up.
    for (n = 0; n < 250; n++) begin
      if ($urandom_range(0, 99) < 58) send_op(KIND_INSERT, $urandom, rand_priority());
      else send_op(KIND_EXTRACT, $urandom, $urandom);
    end

    // Fill to capacity with the odd extract mixed in; the middle of the climb
    // runs with no idling on either side.
    while (occupancy < int'(HEAP_DEPTH)) begin
      steady = (occupancy >= 300 && occupancy < 600);
      if ($urandom_range(0, 99) < 94) send_op(KIND_INSERT, $urandom, rand_priority());
      else send_op(KIND_EXTRACT, $urandom, $urandom);
    end
    steady = 1'b0;

    // Work at the full boundary: refused inserts and deep sift-downs.
    for (n = 0; n < 30; n++) begin
      if ($urandom_range(0, 99) < 60) send_op(KIND_INSERT, $urandom, rand_priority());
      else send_op(KIND_EXTRACT, $urandom, $urandom);
    end

    // Drain a good part of the full heap.
    for (n = 0; n < 150; n++) begin
      if ($urandom_range(0, 99) < 85) send_op(KIND_EXTRACT, $urandom, $urandom);
      else send_op(KIND_INSERT, $urandom, rand_priority());
    end
    req.valid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d inserts and %0d extracts, peak fill %0d of %0d entries.",
             inserts, extracts, peak_fill, HEAP_DEPTH);
    $display("Extracts from an empty heap: %0d, inserts refused at full: %0d.",
             empty_hits, full_hits);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case a transfer never completes.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d responses still outstanding.", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
